@@ hdl/rbvg_pkg.sv @@
// Shared types and constants for the range and bearing visibility gate.
// Holds the CORDIC arctangent table, register indexes and the result word layout.
// No dependencies.
package rbvg_pkg;

	localparam int TABLE_LEN   = 24;
	localparam int TABLE_IDX_W = 5;
	localparam int Z_W         = 32;
	localparam int ANGLE_W     = 16;
	localparam int RANGE_W     = 23;
	localparam int PRE_SHIFT   = 8;
	localparam int OUT_TDATA_W = 8;
	localparam int CFG_IDX_W   = 2;

	// atan(2^-i) scaled to 2^32 units per turn, rounded to nearest.
	localparam logic [Z_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_RANGE  = 2'd0,
		REG_MAX_RANGE  = 2'd1,
		REG_VIEW_WIDTH = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic in_view;
		logic in_range;
		logic visible;
	} rbvg_result_t;

endpackage

@@ hdl/rbvg_cordic_stage.sv @@
// One registered iteration of the vectoring CORDIC used for the bearing.
// Depends on rbvg_pkg for the arctangent table and the angle width.
// The stage advances only when its enable is high.
module rbvg_cordic_stage
	import rbvg_pkg::*;
#(
	parameter int CW   = 35,
	parameter int STEP = 0
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW-1:0] x_in,
	input  logic signed [CW-1:0] y_in,
	input  logic [Z_W-1:0]       z_in,
	output logic signed [CW-1:0] x_out,
	output logic signed [CW-1:0] y_out,
	output logic [Z_W-1:0]       z_out
);

	localparam logic [TABLE_IDX_W-1:0] IDX = TABLE_IDX_W'(STEP);
	localparam logic [Z_W-1:0] ANGLE = ATAN_TABLE[IDX];

	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;

	assign xs = x_in >>> STEP;
	assign ys = y_in >>> STEP;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[CW-1]) begin
				x_out <= x_in + ys;
				y_out <= y_in - xs;
				z_out <= z_in + ANGLE;
			end else begin
				x_out <= x_in - ys;
				y_out <= y_in + xs;
				z_out <= z_in - ANGLE;
			end
		end
	end

endmodule

@@ hdl/range_bearing_visibility_gate_core.sv @@
// Range and bearing visibility gate: top level with stream ports and register file.
// Depends on rbvg_pkg and rbvg_cordic_stage.
//
// Each input word carries an object position, the vessel position and the vessel heading;
// the block returns one result word per input word telling whether the object lies within
// the configured range band and inside the field of view. The datapath is a fully unrolled
// pipeline: one stage forms the differences, one takes magnitudes and sets up the CORDIC,
// ANGLE_STEPS stages each run one CORDIC iteration, and one stage rounds the bearing before
// the result is loaded into the output register. A new word is accepted in every cycle while
// the skid entry is empty; throughput is one word per clock, set by the unrolled CORDIC chain,
// while the output does not stall. A two-entry output buffer lets the pipeline keep
// taking words while one result waits on the output. Register writes pass through the
// configuration and squared-range registers and must be made while no word is in flight.
module range_bearing_visibility_gate_core
	import rbvg_pkg::*;
#(
	parameter int ANGLE_STEPS    = 16,
	parameter int POSITION_WIDTH = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// target_x, target_y, vessel_x, vessel_y, vessel_heading, zero padding
	input  logic [((4*POSITION_WIDTH+ANGLE_W+7)/8)*8-1:0] s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// visible, in_range, in_view, zero padding
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [RANGE_W-1:0]     cfg_data
);

	localparam int PW    = POSITION_WIDTH;
	localparam int CW    = PW + 11;
	localparam int CMP_W = (PW + 1 > RANGE_W) ? PW + 1 : RANGE_W;
	localparam int SQ_W  = 2 * RANGE_W;
	localparam int N     = ANGLE_STEPS;

	// Configuration registers
	logic [RANGE_W-1:0] min_range_q;
	logic [RANGE_W-1:0] max_range_q;
	logic [ANGLE_W-1:0] view_width_q;
	logic [SQ_W-1:0]    min_sq_q;
	logic [SQ_W-1:0]    max_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_q  <= RANGE_W'(256);
			max_range_q  <= RANGE_W'(5120);
			view_width_q <= ANGLE_W'(14200);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_RANGE:  min_range_q  <= cfg_data;
				REG_MAX_RANGE:  max_range_q  <= cfg_data;
				REG_VIEW_WIDTH: view_width_q <= cfg_data[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		min_sq_q <= SQ_W'(min_range_q) * SQ_W'(min_range_q);
		max_sq_q <= SQ_W'(max_range_q) * SQ_W'(max_range_q);
	end

	// Handshake control
	logic en;
	logic skid_v_q;
	logic out_v_q;

	assign en       = !skid_v_q;
	assign s_tready = en;

	// Stage 1: differences
	logic signed [PW-1:0] tx, ty, vx, vy;
	logic [ANGLE_W-1:0]   hd;

	assign tx = s_tdata[PW-1:0];
	assign ty = s_tdata[2*PW-1:PW];
	assign vx = s_tdata[3*PW-1:2*PW];
	assign vy = s_tdata[4*PW-1:3*PW];
	assign hd = s_tdata[4*PW+ANGLE_W-1:4*PW];

	logic                 v_s1;
	logic signed [PW:0]   dx_s1, dy_s1;
	logic [ANGLE_W-1:0]   head_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= (PW+1)'(tx) - (PW+1)'(vx);
			dy_s1   <= (PW+1)'(ty) - (PW+1)'(vy);
			head_s1 <= hd;
		end
	end

	// Stage 2: magnitudes, far test and CORDIC set-up
	logic [PW:0]          ax, ay;
	logic [CMP_W-1:0]     ax_w, ay_w;
	logic signed [CW-1:0] dx_w, dy_w, xi, yi;
	logic                 near_c, zero_c;

	always_comb begin
		ax     = dx_s1[PW] ? (PW+1)'(-dx_s1) : dx_s1;
		ay     = dy_s1[PW] ? (PW+1)'(-dy_s1) : dy_s1;
		ax_w   = CMP_W'(ax);
		ay_w   = CMP_W'(ay);
		near_c = (ax_w <= CMP_W'(max_range_q)) && (ay_w <= CMP_W'(max_range_q));
		zero_c = (dx_s1 == '0) && (dy_s1 == '0);
		dx_w   = CW'(dx_s1);
		dy_w   = CW'(dy_s1);
		xi     = dx_s1[PW] ? -dx_w : dx_w;
		yi     = dx_s1[PW] ? -dy_w : dy_w;
	end

	logic                 v_s2, near_s2, zero_s2;
	logic [RANGE_W-1:0]   ax_s2, ay_s2;
	logic signed [CW-1:0] x_s2, y_s2;
	logic [Z_W-1:0]       z_s2;
	logic [ANGLE_W-1:0]   head_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			near_s2 <= near_c;
			zero_s2 <= zero_c;
			ax_s2   <= ax_w[RANGE_W-1:0];
			ay_s2   <= ay_w[RANGE_W-1:0];
			x_s2    <= xi <<< PRE_SHIFT;
			y_s2    <= yi <<< PRE_SHIFT;
			z_s2    <= {dx_s1[PW], {(Z_W-1){1'b0}}};
			head_s2 <= head_s1;
		end
	end

	// CORDIC stages, with range test and side data alongside
	logic signed [CW-1:0] cx_s [N];
	logic signed [CW-1:0] cy_s [N];
	logic [Z_W-1:0]       cz_s [N];
	logic                 vld_s  [N];
	logic                 zero_s [N];
	logic                 rng_s  [N];
	logic [ANGLE_W-1:0]   head_s [N];

	for (genvar k = 0; k < N; k++) begin : g_cordic
		if (k == 0) begin : g_first
			rbvg_cordic_stage #(.CW(CW), .STEP(k)) u_stage (
				.clk(clk), .en(en),
				.x_in(x_s2), .y_in(y_s2), .z_in(z_s2),
				.x_out(cx_s[k]), .y_out(cy_s[k]), .z_out(cz_s[k])
			);
		end else begin : g_next
			rbvg_cordic_stage #(.CW(CW), .STEP(k)) u_stage (
				.clk(clk), .en(en),
				.x_in(cx_s[k-1]), .y_in(cy_s[k-1]), .z_in(cz_s[k-1]),
				.x_out(cx_s[k]), .y_out(cy_s[k]), .z_out(cz_s[k])
			);
		end
	end

	logic [SQ_W-1:0] sq_x_s3, sq_y_s3;
	logic [SQ_W:0]   d2;
	logic            band_ok;

	assign d2      = (SQ_W+1)'(sq_x_s3) + (SQ_W+1)'(sq_y_s3);
	assign band_ok = (d2 >= (SQ_W+1)'(min_sq_q)) && (d2 <= (SQ_W+1)'(max_sq_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '{default: 1'b0};
		end else if (en) begin
			vld_s[0] <= v_s2;
			for (int k = 1; k < N; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_x_s3   <= SQ_W'(ax_s2) * SQ_W'(ax_s2);
			sq_y_s3   <= SQ_W'(ay_s2) * SQ_W'(ay_s2);
			zero_s[0] <= zero_s2;
			rng_s[0]  <= near_s2;
			head_s[0] <= head_s2;
			for (int k = 1; k < N; k++) begin
				zero_s[k] <= zero_s[k-1];
				head_s[k] <= head_s[k-1];
			end
			rng_s[1] <= rng_s[0] && band_ok;
			for (int k = 2; k < N; k++) begin
				rng_s[k] <= rng_s[k-1];
			end
		end
	end

	// Final stage: bearing rounded to the heading resolution
	logic [Z_W-1:0]     z_rnd;
	logic               v_sf, rng_sf;
	logic [ANGLE_W-1:0] bearing_sf, head_sf;

	assign z_rnd = cz_s[N-1] + Z_W'(32'h0000_8000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sf <= 1'b0;
		end else if (en) begin
			v_sf <= vld_s[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bearing_sf <= zero_s[N-1] ? '0 : z_rnd[Z_W-1:Z_W-ANGLE_W];
			head_sf    <= head_s[N-1];
			rng_sf     <= rng_s[N-1];
		end
	end

	// View test and result word
	logic [ANGLE_W-1:0] diff;
	logic [ANGLE_W:0]   mag;
	logic               view_ok;
	logic               push;
	rbvg_result_t       res;

	always_comb begin
		diff         = head_sf - bearing_sf;
		mag          = diff[ANGLE_W-1] ? ((ANGLE_W+1)'(1) << ANGLE_W) - (ANGLE_W+1)'(diff)
		                               : (ANGLE_W+1)'(diff);
		view_ok      = {mag, 1'b0} < (ANGLE_W+2)'(view_width_q);
		res.in_view  = view_ok;
		res.in_range = rng_sf;
		res.visible  = rng_sf && view_ok;
	end

	assign push = en && v_sf;

	// Output register with skid entry
	rbvg_result_t out_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {(OUT_TDATA_W-3)'(0), out_q};

	// Checks
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held while output register empty");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_s1)
		else $error("accepted word did not enter the first stage");

	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !m_tready && push) |=> (skid_v_q && out_v_q))
		else $error("result produced during output stall was not buffered");

	a_visible_and: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[1] && m_tdata[2])))
		else $error("visible flag disagrees with range and view flags");

endmodule
